// ----- rtl/alarm_match_snooze_controller_unit_macros.svh -----
// assertion macros for the alarm match and snooze controller
`ifndef ALARM_MATCH_SNOOZE_CONTROLLER_UNIT_MACROS_SVH
`define ALARM_MATCH_SNOOZE_CONTROLLER_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define AMSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AMSC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define AMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/amsc_pkg.sv -----
// types and constants shared by the alarm match and snooze controller
`timescale 1ns / 1ps

package amsc_pkg;

    // command codes
    localparam logic [1:0] CMD_TIME_UPDATE = 2'd0;
    localparam logic [1:0] CMD_KEY_PRESS   = 2'd1;
    localparam logic [1:0] CMD_TICK        = 2'd2;

    // key codes
    localparam logic [1:0] KEY_ARM    = 2'd0;
    localparam logic [1:0] KEY_DISARM = 2'd1;
    localparam logic [1:0] KEY_MENU   = 2'd2;
    localparam logic [1:0] KEY_SNOOZE = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOUR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MINUTE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SNOOZE_SEC   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RING_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CATCHUP_MIN  = 3'd4;

    // indicator codes
    localparam logic [1:0] IND_DISARMED = 2'd0;
    localparam logic [1:0] IND_ARMED    = 2'd1;
    localparam logic [1:0] IND_SNOOZING = 2'd2;

    // calendar constants
    localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
    localparam logic [12:0] MINUTES_PER_DAY  = 13'd1440;
    localparam logic [7:0]  LAST_HOUR        = 8'd23;
    localparam logic [7:0]  LAST_MINUTE      = 8'd59;
    localparam logic [3:0]  MONTH_DECEMBER   = 4'd11;
    localparam logic [4:0]  LAST_DAY_DEC     = 5'd31;
    localparam logic [4:0]  FIRST_DAY        = 5'd1;

    // reset values of the configuration registers
    localparam logic [7:0] RST_ALARM_HOUR   = 8'd255;
    localparam logic [7:0] RST_ALARM_MINUTE = 8'd255;
    localparam logic [9:0] RST_SNOOZE_SEC   = 10'd540;
    localparam logic [9:0] RST_RING_LIMIT   = 10'd300;
    localparam logic [5:0] RST_CATCHUP_MIN  = 6'd10;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] key;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [8:0] day_of_year;
        logic [7:0] year;
    } in_item_t;

    typedef struct packed {
        logic       ringing;
        logic       armed;
        logic       snoozing;
        logic [1:0] indicator;
        logic       ring_started;
        logic       ring_stopped;
        logic       open_menu;
    } out_item_t;

endpackage

// ----- rtl/amsc_if.sv -----
// request channel interfaces for the alarm match and snooze controller
`timescale 1ns / 1ps

interface amsc_in_if
    import amsc_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface amsc_out_if
    import amsc_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ----- rtl/alarm_match_snooze_controller_unit.sv -----
// alarm match and snooze controller top level
//
//  channel   | direction | handshake    | payload
//  ----------+-----------+--------------+---------------------------------------------
//  in_chan   | in        | valid/ready  | command, key, hour, minute, date fields
//  out_chan  | out       | valid/ready  | ringing, armed, snoozing, indicator, pulses
//  cfg       | in        | cfg_we       | cfg_index, cfg_data (write only)
//
// one request per cycle sustained while the output is not stalled; a request taken into
// the input stage has its result registered in the output stage once the input stage advances
// stage one holds the request, stage two applies it to the state and registers the result
// the state update for one request is a single pass of compares and counter steps
// rst_n clears the control state and loads the register defaults (no alarm time set)
// a stalled output holds its result; the input stage fills and then ready drops
`timescale 1ns / 1ps
`include "alarm_match_snooze_controller_unit_macros.svh"

module alarm_match_snooze_controller_unit
    import amsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    amsc_in_if.sink                in_chan,
    amsc_out_if.source             out_chan,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [7:0] alarm_hour_reg;
    logic [7:0] alarm_minute_reg;
    logic [9:0] snooze_sec_reg;
    logic [9:0] ring_limit_reg;
    logic [5:0] catchup_reg;

    // input stage
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     advance;

    // output stage
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // controller state
    logic       armed_reg, armed_next;
    logic       ringing_reg, ringing_next;
    logic [9:0] snooze_left_reg, snooze_left_next;
    logic [9:0] ring_left_reg, ring_left_next;
    logic [10:0] prev_minutes_reg;
    logic [4:0] prev_dom_reg;
    logic [3:0] prev_month_reg;
    logic [8:0] prev_doy_reg;
    logic [7:0] prev_year_reg;

    // alarm match datapath
    logic        alarm_valid;
    logic [10:0] cur_min;
    logic [10:0] target_min;
    logic signed [12:0] cur_s, target_s, prev_s, prev_wrap_s, catchup_s;
    logic        hit_same, hit_wrap;
    logic        same_day, next_day;
    logic        alarm_due;
    logic        started, stopped, menu;

    // ------------------------------------------------------------------
    // handshake: the input stage refills in the cycle it hands its request on
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready = !in_valid_reg || advance;
    assign out_chan.valid = out_valid_reg;
    assign out_chan.item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_chan.ready)
            begin
                in_valid_reg <= in_chan.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            in_item_reg <= in_chan.item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration writes, indexes beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_hour_reg   <= RST_ALARM_HOUR;
            alarm_minute_reg <= RST_ALARM_MINUTE;
            snooze_sec_reg   <= RST_SNOOZE_SEC;
            ring_limit_reg   <= RST_RING_LIMIT;
            catchup_reg      <= RST_CATCHUP_MIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALARM_HOUR:   alarm_hour_reg   <= cfg_data[7:0];
                REG_ALARM_MINUTE: alarm_minute_reg <= cfg_data[7:0];
                REG_SNOOZE_SEC:   snooze_sec_reg   <= cfg_data;
                REG_RING_LIMIT:   ring_limit_reg   <= cfg_data;
                REG_CATCHUP_MIN:  catchup_reg      <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // alarm match: exact minute, or a skipped minute inside the catch-up window
    // ------------------------------------------------------------------
    assign alarm_valid = (alarm_hour_reg <= LAST_HOUR) && (alarm_minute_reg <= LAST_MINUTE);
    // max 31*60+63 fits in 11 bits
    assign cur_min    = ({6'd0, in_item_reg.hour} * MINUTES_PER_HOUR)
                        + {5'd0, in_item_reg.minute};
    assign target_min = ({6'd0, alarm_hour_reg[4:0]} * MINUTES_PER_HOUR)
                        + {5'd0, alarm_minute_reg[5:0]};

    assign cur_s       = $signed({2'b00, cur_min});
    assign target_s    = $signed({2'b00, target_min});
    assign prev_s      = $signed({2'b00, prev_minutes_reg});
    // previous time seen from the new day, one day back
    assign prev_wrap_s = prev_s - $signed(MINUTES_PER_DAY);
    assign catchup_s   = $signed({7'd0, catchup_reg});

    assign hit_same = (cur_s >= target_s) && (prev_s < target_s)
                      && ((cur_s - prev_s) <= catchup_s);
    assign hit_wrap = (cur_s >= target_s) && (prev_wrap_s < target_s)
                      && ((cur_s - prev_wrap_s) <= catchup_s);

    assign same_day = (prev_year_reg == in_item_reg.year)
                      && (prev_doy_reg == in_item_reg.day_of_year);
    // next day in the same year, or new year's eve to the first of the next year
    assign next_day = ((prev_year_reg == in_item_reg.year)
                       && (({1'b0, prev_doy_reg} + 10'd1) == {1'b0, in_item_reg.day_of_year}))
                      || ((({1'b0, prev_year_reg} + 9'd1) == {1'b0, in_item_reg.year})
                          && (prev_month_reg == MONTH_DECEMBER)
                          && (prev_dom_reg == LAST_DAY_DEC)
                          && (in_item_reg.day_of_month == FIRST_DAY));

    // no previous time (day of month zero) allows the exact match only
    assign alarm_due = alarm_valid
                       && ((cur_min == target_min)
                           || ((prev_dom_reg != 5'd0)
                               && (same_day ? hit_same : (next_day && hit_wrap))));

    // ------------------------------------------------------------------
    // state update for the request in the input stage
    // ------------------------------------------------------------------
    always_comb
    begin
        armed_next       = armed_reg;
        ringing_next     = ringing_reg;
        snooze_left_next = snooze_left_reg;
        ring_left_next   = ring_left_reg;
        started          = 1'b0;
        stopped          = 1'b0;
        menu             = 1'b0;

        unique case (in_item_reg.command)
            CMD_TIME_UPDATE:
            begin
                if (armed_reg && !ringing_reg && (snooze_left_reg == 10'd0) && alarm_due)
                begin
                    ringing_next   = 1'b1;
                    ring_left_next = ring_limit_reg;
                    started        = 1'b1;
                end
            end
            CMD_KEY_PRESS:
            begin
                priority if (((in_item_reg.key == KEY_ARM) && !armed_reg)
                             || ((in_item_reg.key == KEY_DISARM) && armed_reg))
                begin
                    // arm or disarm cancels ringing and snooze
                    armed_next       = (in_item_reg.key == KEY_ARM);
                    stopped          = ringing_reg;
                    ringing_next     = 1'b0;
                    snooze_left_next = 10'd0;
                    ring_left_next   = 10'd0;
                end
                else if (in_item_reg.key == KEY_MENU)
                begin
                    if (!ringing_reg)
                    begin
                        menu             = 1'b1;
                        snooze_left_next = 10'd0;
                    end
                end
                else if (in_item_reg.key == KEY_SNOOZE)
                begin
                    if (ringing_reg && (snooze_left_reg == 10'd0))
                    begin
                        snooze_left_next = snooze_sec_reg;
                        ringing_next     = 1'b0;
                        ring_left_next   = 10'd0;
                        stopped          = 1'b1;
                    end
                end
                else
                begin
                    // arm while armed or disarm while disarmed is ignored
                end
            end
            CMD_TICK:
            begin
                // ring limit countdown first
                if (ringing_reg)
                begin
                    if (ring_left_reg <= 10'd1)
                    begin
                        ringing_next   = 1'b0;
                        ring_left_next = 10'd0;
                        stopped        = 1'b1;
                    end
                    else
                    begin
                        ring_left_next = ring_left_reg - 10'd1;
                    end
                end
                // then snooze countdown, expiry re-rings when still armed
                if (snooze_left_reg != 10'd0)
                begin
                    snooze_left_next = snooze_left_reg - 10'd1;
                    if ((snooze_left_next == 10'd0) && armed_reg && !ringing_next)
                    begin
                        ringing_next   = 1'b1;
                        ring_left_next = ring_limit_reg;
                        started        = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused command leaves everything as is
            end
        endcase

        out_item_next.ringing      = ringing_next;
        out_item_next.armed        = armed_next;
        out_item_next.snoozing     = (snooze_left_next != 10'd0);
        out_item_next.indicator    = !armed_next ? IND_DISARMED
                                     : ((snooze_left_next != 10'd0) ? IND_SNOOZING : IND_ARMED);
        out_item_next.ring_started = started;
        out_item_next.ring_stopped = stopped;
        out_item_next.open_menu    = menu;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            ringing_reg      <= 1'b0;
            snooze_left_reg  <= 10'd0;
            ring_left_reg    <= 10'd0;
            prev_minutes_reg <= 11'd0;
            prev_dom_reg     <= 5'd0;
            prev_month_reg   <= 4'd0;
            prev_doy_reg     <= 9'd0;
            prev_year_reg    <= 8'd0;
        end
        else if (advance)
        begin
            armed_reg       <= armed_next;
            ringing_reg     <= ringing_next;
            snooze_left_reg <= snooze_left_next;
            ring_left_reg   <= ring_left_next;
            // every time update becomes the previous time
            if (in_item_reg.command == CMD_TIME_UPDATE)
            begin
                prev_minutes_reg <= cur_min;
                prev_dom_reg     <= in_item_reg.day_of_month;
                prev_month_reg   <= in_item_reg.month;
                prev_doy_reg     <= in_item_reg.day_of_year;
                prev_year_reg    <= in_item_reg.year;
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `AMSC_ASSERT_ALWAYS(a_ring_snooze_excl,
        !(ringing_reg && (snooze_left_reg != 10'd0)), "ringing while snoozing")
    `AMSC_ASSERT_IMPLIES(a_ring_left_idle,
        !ringing_reg, ring_left_reg == 10'd0, "ring countdown left running")
    `AMSC_ASSERT_IMPLIES(a_started_rings,
        out_valid_reg && out_item_reg.ring_started,
        out_item_reg.ringing && !out_item_reg.ring_stopped, "start pulse without ringing")
    `AMSC_ASSERT_NEXT(a_held_request,
        in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "held request lost")

endmodule
